// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks that a condition seen at one edge is followed by a result at the next
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// checks a condition that must hold in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: src/mai_pkg.sv
package mai_pkg;

   localparam int PRICE_W = 32;

   localparam int SHORT_WINDOW = 10;
   localparam int MID_WINDOW = 25;
   localparam int LONG_WINDOW = 50;
   localparam int EXP_PERIOD = 5;

   localparam int MAX_SM = (SHORT_WINDOW > MID_WINDOW) ? SHORT_WINDOW : MID_WINDOW;
   localparam int MAX_LE = (LONG_WINDOW > EXP_PERIOD) ? LONG_WINDOW : EXP_PERIOD;
   localparam int MAX_WINDOW = (MAX_SM > MAX_LE) ? MAX_SM : MAX_LE;
   localparam int HIST_DEPTH = MAX_WINDOW;

   // one above the widest window so the reseed compare never sticks
   localparam int COUNT_MAX = MAX_WINDOW + 1;
   localparam int COUNT_W = $clog2(COUNT_MAX + 1);

   localparam int SUM_W = PRICE_W + $clog2(MAX_WINDOW);
   localparam int RECIP_W = SUM_W + 1;
   localparam int DIV_SPLIT = (RECIP_W + 1) / 2;
   localparam int RECIP_HI_W = RECIP_W - DIV_SPLIT;
   localparam int PROD_W = SUM_W + RECIP_W;

   localparam int NUM_LANES = 4;
   localparam int LANE_SHORT = 0;
   localparam int LANE_MID = 1;
   localparam int LANE_LONG = 2;
   localparam int LANE_SEED = 3;

   localparam int LANE_WIN [NUM_LANES] = '{SHORT_WINDOW, MID_WINDOW, LONG_WINDOW, EXP_PERIOD};
   localparam int LANE_SHIFT [NUM_LANES] = '{
      $clog2(SHORT_WINDOW), $clog2(MID_WINDOW), $clog2(LONG_WINDOW), $clog2(EXP_PERIOD)
   };

   // ceil(2^(SUM_W+shift) / window): exact truncating quotient for any sum below 2^SUM_W
   localparam logic [RECIP_W-1:0] LANE_RECIP [NUM_LANES] = '{
      RECIP_W'(((64'd1 << (SUM_W + $clog2(SHORT_WINDOW))) + 64'(SHORT_WINDOW - 1))
         / 64'(SHORT_WINDOW)),
      RECIP_W'(((64'd1 << (SUM_W + $clog2(MID_WINDOW))) + 64'(MID_WINDOW - 1))
         / 64'(MID_WINDOW)),
      RECIP_W'(((64'd1 << (SUM_W + $clog2(LONG_WINDOW))) + 64'(LONG_WINDOW - 1))
         / 64'(LONG_WINDOW)),
      RECIP_W'(((64'd1 << (SUM_W + $clog2(EXP_PERIOD))) + 64'(EXP_PERIOD - 1))
         / 64'(EXP_PERIOD))
   };

   // ema step: prev + floor(2*(price - prev) / EMA_DIV), biased to stay non-negative
   localparam int EMA_DIV = EXP_PERIOD + 1;
   localparam int EMA_SHIFT = $clog2(EMA_DIV);
   localparam int EMA_W = PRICE_W + 3;
   localparam int EMA_RECIP_W = EMA_W + 1;
   localparam int EMA_PROD_W = EMA_W + EMA_RECIP_W;
   localparam int EMA_Q_W = EMA_W - EMA_SHIFT + 1;
   localparam logic [EMA_RECIP_W-1:0] EMA_RECIP =
      EMA_RECIP_W'(((64'd1 << (EMA_W + EMA_SHIFT)) + 64'(EMA_DIV - 1)) / 64'(EMA_DIV));
   localparam logic [EMA_W-1:0] EMA_BIAS_Q =
      EMA_W'(((64'd1 << (PRICE_W + 1)) + 64'(EMA_DIV - 1)) / 64'(EMA_DIV));
   localparam logic [EMA_W-1:0] EMA_BIAS = EMA_W'(64'(EMA_BIAS_Q) * 64'(EMA_DIV));

   typedef struct packed {
      logic [PRICE_W-1:0] close_price;
      logic               start_series;
   } req_type;

   typedef struct packed {
      logic [PRICE_W-1:0] short_average;
      logic [PRICE_W-1:0] mid_average;
      logic [PRICE_W-1:0] long_average;
      logic [PRICE_W-1:0] exp_average;
   } rsp_type;

   typedef logic [NUM_LANES-1:0][SUM_W-1:0] sum_vec_type;
   typedef logic [NUM_LANES-1:0][PRICE_W-1:0] quot_vec_type;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [COUNT_W-1:0] count;
   } item_meta_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
   } div_ctrl_type;

   typedef struct packed {
      logic               advance;
      logic [PRICE_W-1:0] price;
      logic [COUNT_W-1:0] count;
      logic [PRICE_W-1:0] seed_mean;
   } ema_ctrl_type;

endpackage

// File: src/mai_cell.sv
module mai_cell (
   input  logic                        clock,
   input  logic                        shift,
   input  logic [mai_pkg::PRICE_W-1:0] chain_in,
   output logic [mai_pkg::PRICE_W-1:0] chain_out
);
   import mai_pkg::*;

   logic [PRICE_W-1:0] held_ff;
   logic [PRICE_W-1:0] held_in;

   always_comb begin
      held_in = shift ? chain_in : held_ff;
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   assign chain_out = held_ff;

endmodule

// File: src/mai_div.sv
module mai_div (
   input  logic                  clock,
   input  mai_pkg::div_ctrl_type ctrl,
   input  mai_pkg::sum_vec_type  sums,
   output mai_pkg::quot_vec_type quots
);
   import mai_pkg::*;

   logic [SUM_W+DIV_SPLIT-1:0]  pp_lo_ff [NUM_LANES];
   logic [SUM_W+DIV_SPLIT-1:0]  pp_lo_in [NUM_LANES];
   logic [SUM_W+RECIP_HI_W-1:0] pp_hi_ff [NUM_LANES];
   logic [SUM_W+RECIP_HI_W-1:0] pp_hi_in [NUM_LANES];
   quot_vec_type                quot_ff;
   quot_vec_type                quot_in;

   for (genvar lane = 0; lane < NUM_LANES; lane++) begin : g_lane
      logic [PROD_W-1:0] prod;

      // reciprocal split in two halves, one partial product each
      assign pp_lo_in[lane] = ctrl.load_a
         ? (SUM_W+DIV_SPLIT)'(sums[lane])
            * (SUM_W+DIV_SPLIT)'(LANE_RECIP[lane][DIV_SPLIT-1:0])
         : pp_lo_ff[lane];
      assign pp_hi_in[lane] = ctrl.load_a
         ? (SUM_W+RECIP_HI_W)'(sums[lane])
            * (SUM_W+RECIP_HI_W)'(LANE_RECIP[lane][RECIP_W-1:DIV_SPLIT])
         : pp_hi_ff[lane];

      assign prod = {pp_hi_ff[lane], DIV_SPLIT'(0)} + PROD_W'(pp_lo_ff[lane]);
      assign quot_in[lane] = ctrl.load_b
         ? prod[SUM_W+LANE_SHIFT[lane] +: PRICE_W]
         : quot_ff[lane];
   end

   always_ff @(posedge clock) begin
      pp_lo_ff <= pp_lo_in;
      pp_hi_ff <= pp_hi_in;
      quot_ff  <= quot_in;
   end

   assign quots = quot_ff;

endmodule

// File: src/mai_ema.sv
module mai_ema (
   input  logic                        clock,
   input  mai_pkg::ema_ctrl_type       ctrl,
   output logic [mai_pkg::PRICE_W-1:0] exp_average
);
   import mai_pkg::*;

   logic [PRICE_W-1:0]    exp_ff;
   logic [PRICE_W-1:0]    exp_in;
   logic [PRICE_W-1:0]    seed_ff;
   logic [PRICE_W-1:0]    seed_in;
   logic                  active;
   logic                  reseed;
   logic [PRICE_W-1:0]    prev;
   logic [EMA_W-1:0]      biased;
   logic [EMA_PROD_W-1:0] prod;
   logic [EMA_Q_W-1:0]    quot;
   logic [EMA_W-1:0]      step;

   always_comb begin
      active = ctrl.count >= COUNT_W'(EXP_PERIOD);
      reseed = ctrl.count == COUNT_W'(EXP_PERIOD);
      // on the first ema sample the previous value is the seed mean of the beat before
      prev   = reseed ? seed_ff : exp_ff;
      biased = EMA_W'({ctrl.price, 1'b0}) - EMA_W'({prev, 1'b0}) + EMA_BIAS;
      prod   = EMA_PROD_W'(biased) * EMA_PROD_W'(EMA_RECIP);
      quot   = prod[EMA_W+EMA_SHIFT +: EMA_Q_W];
      step   = EMA_W'(prev) + EMA_W'(quot) - EMA_BIAS_Q;

      exp_average = active ? step[PRICE_W-1:0] : '0;
      exp_in      = (ctrl.advance && active) ? step[PRICE_W-1:0] : exp_ff;
      seed_in     = ctrl.advance ? ctrl.seed_mean : seed_ff;
   end

   always_ff @(posedge clock) begin
      exp_ff  <= exp_in;
      seed_ff <= seed_in;
   end

endmodule

// File: src/moving_average_indicators.sv
// path: an accepted price moves through the s1, s2 and s3 registers into the output register, and any stall holds it
// throughput: one price per cycle, sustained while rsp_ready stays high
// the rate is set by the ema update, whose add and constant divide are combinational
// the price history is a row of shift cells, one per sample of the longest window
// reset clears the window sums, the sample count and all stage valids; no clearing pass
`include "assert_macros.svh"

module moving_average_indicators (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mai_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mai_pkg::rsp_type rsp_payload
);
   import mai_pkg::*;

   logic [PRICE_W-1:0] cell_out [HIST_DEPTH];
   logic               req_accept;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] pcount;
   sum_vec_type        sum_ff;
   sum_vec_type        sum_in;
   sum_vec_type        sum_next;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic [COUNT_W-1:0] s1_count_ff;
   logic [COUNT_W-1:0] s1_count_in;
   logic               s2_valid_ff;
   logic               s2_valid_in;
   item_meta_type      s2_meta_ff;
   item_meta_type      s2_meta_in;
   logic               s3_valid_ff;
   logic               s3_valid_in;
   item_meta_type      s3_meta_ff;
   item_meta_type      s3_meta_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_payload_ff;
   rsp_type            rsp_payload_in;
   rsp_type            rsp_next;

   logic               out_free;
   logic               s3_move;
   logic               s3_free;
   logic               s2_move;
   logic               s2_free;
   logic               s1_move;
   logic               s1_free;

   div_ctrl_type       div_ctrl;
   quot_vec_type       quots;
   ema_ctrl_type       ema_ctrl;
   logic [PRICE_W-1:0] exp_average;

   // stages advance into any free slot so bubbles close up behind a stalled output
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_ready;
      s3_move    = s3_valid_ff && out_free;
      s3_free    = !s3_valid_ff || out_free;
      s2_move    = s2_valid_ff && s3_free;
      s2_free    = !s2_valid_ff || s3_free;
      s1_move    = s1_valid_ff && s2_free;
      s1_free    = !s1_valid_ff || s2_free;
      req_accept = req_valid && s1_free;
   end

   assign req_ready = s1_free;

   for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         mai_cell u_cell (
            .clock     (clock),
            .shift     (req_accept),
            .chain_in  (req_payload.close_price),
            .chain_out (cell_out[i])
         );
      end else begin : g_body
         mai_cell u_cell (
            .clock     (clock),
            .shift     (req_accept),
            .chain_in  (cell_out[i-1]),
            .chain_out (cell_out[i])
         );
      end
   end

   assign pcount = req_payload.start_series ? '0 : count_ff;

   for (genvar lane = 0; lane < NUM_LANES; lane++) begin : g_sum
      logic [SUM_W-1:0] base;
      logic             full;

      assign base = req_payload.start_series ? '0 : sum_ff[lane];
      // the cell one window deep holds the price that leaves this window
      assign full = pcount >= COUNT_W'(LANE_WIN[lane]);
      assign sum_next[lane] = base + SUM_W'(req_payload.close_price)
         - (full ? SUM_W'(cell_out[LANE_WIN[lane]-1]) : SUM_W'(0));
   end

   always_comb begin
      sum_in      = req_accept ? sum_next : sum_ff;
      count_in    = count_ff;
      s1_count_in = s1_count_ff;
      if (req_accept) begin
         count_in    = (pcount == COUNT_W'(COUNT_MAX)) ? pcount : pcount + COUNT_W'(1);
         s1_count_in = pcount;
      end

      s1_valid_in  = req_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_valid_ff);
      s3_valid_in  = s2_move ? 1'b1 : (s3_move ? 1'b0 : s3_valid_ff);
      rsp_valid_in = s3_move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

      // stage one reads the live sums and head cell: nothing is accepted while it holds
      s2_meta_in.price = cell_out[0];
      s2_meta_in.count = s1_count_ff;
      if (!s1_move) begin
         s2_meta_in = s2_meta_ff;
      end
      s3_meta_in = s2_move ? s2_meta_ff : s3_meta_ff;

      rsp_next.short_average = (s3_meta_ff.count >= COUNT_W'(SHORT_WINDOW - 1))
         ? quots[LANE_SHORT] : '0;
      rsp_next.mid_average = (s3_meta_ff.count >= COUNT_W'(MID_WINDOW - 1))
         ? quots[LANE_MID] : '0;
      rsp_next.long_average = (s3_meta_ff.count >= COUNT_W'(LONG_WINDOW - 1))
         ? quots[LANE_LONG] : '0;
      rsp_next.exp_average = exp_average;
      rsp_payload_in = s3_move ? rsp_next : rsp_payload_ff;
   end

   assign div_ctrl.load_a = s1_move;
   assign div_ctrl.load_b = s2_move;

   mai_div u_div (
      .clock (clock),
      .ctrl  (div_ctrl),
      .sums  (sum_ff),
      .quots (quots)
   );

   assign ema_ctrl.advance   = s3_move;
   assign ema_ctrl.price     = s3_meta_ff.price;
   assign ema_ctrl.count     = s3_meta_ff.count;
   assign ema_ctrl.seed_mean = quots[LANE_SEED];

   mai_ema u_ema (
      .clock       (clock),
      .ctrl        (ema_ctrl),
      .exp_average (exp_average)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_count_ff    <= s1_count_in;
      s2_meta_ff     <= s2_meta_in;
      s3_meta_ff     <= s3_meta_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `ASSERT_NEXT(a_accept_fills_s1, req_accept, s1_valid_ff, "accepted beat missing from stage one")
   `ASSERT_NEXT(a_s1_inputs_hold, s1_valid_ff && !s1_move, $stable(sum_ff) && $stable(cell_out[0]), "sums moved under a held stage one")
   `ASSERT_NEXT(a_restart_count, req_accept && req_payload.start_series, count_ff == COUNT_W'(1), "new series did not restart the count")
   `ASSERT_NEXT(a_short_not_full, s3_move && (s3_meta_ff.count < COUNT_W'(SHORT_WINDOW - 1)), rsp_payload_ff.short_average == '0, "short average shown before its window filled")
   `ASSERT_IMPLIES(a_no_overrun, rsp_valid_ff && !rsp_ready, !s3_move, "result overwritten while waiting")

endmodule
